// ----- hdl/mrs_pkg.sv -----
// Package for the Modbus RTU register slave: item types, protocol codes and the CRC-16 step.
// It has no dependencies. All modules of the block import it.
`default_nettype none
package mrs_pkg;

   localparam int REG_DEPTH      = 64;
   localparam int REG_ADDR_W     = $clog2(REG_DEPTH);
   localparam int REG_WIDTH      = 16;
   localparam int MAX_READ_REGS  = 29;
   localparam int MAX_WRITE_REGS = 123;

   localparam logic [7:0]  FN_READ_HOLD   = 8'd3;
   localparam logic [7:0]  FN_READ_INPUT  = 8'd4;
   localparam logic [7:0]  FN_WRITE_MULTI = 8'd16;
   localparam logic [7:0]  BCAST_ADDR     = 8'hFF;
   localparam logic [7:0]  STATION_RESET  = 8'd1;
   localparam logic [15:0] CRC_INIT       = 16'hFFFF;
   localparam logic [15:0] CRC_POLY       = 16'hA001;

   localparam logic OP_FRAME_BYTE = 1'b0;
   localparam logic OP_LOAD_INPUT = 1'b1;

   typedef struct packed {
      logic        operation;
      logic [7:0]  data_byte;
      logic        frame_last;
      logic [5:0]  reg_index;
      logic [15:0] reg_value;
   } req_item_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       tx_last;
   } rsp_item_type;

   // One byte through the reflected CRC-16 used by Modbus RTU.
   function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int j = 0; j < 8; j++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage
`default_nettype wire

// ----- hdl/mrs_regfile.sv -----
// Register store: one synchronous memory with one write and one registered read port.
// Per-entry valid bits make unwritten entries read as zero after reset. Uses mrs_pkg.
`default_nettype none
module mrs_regfile
   import mrs_pkg::*;
#(
   parameter int DEPTH = REG_DEPTH,
   parameter int WIDTH = REG_WIDTH
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [WIDTH-1:0] data_ff;
   logic             hit_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         hit_ff   <= 1'b0;
      end else begin
         if (rd_en) begin
            hit_ff <= valid_ff[rd_addr];
         end
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   assign rd_data = hit_ff ? data_ff : '0;

endmodule
`default_nettype wire

// ----- hdl/modbus_rtu_register_slave_unit.sv -----
// Top level of the Modbus RTU register slave: frame parser, reply sequencer, two stores.
// Depends on mrs_pkg and mrs_regfile.
//
// The block takes one item per handshake: either a received request byte, with a mark on the
// last byte of the frame, or a load of one input register from the application. While no reply
// is being sent, request bytes and loads are taken one per cycle. Holding register writes of a
// multiple write frame are stored as each word completes. At the marked byte of a valid read
// (function 3 or 4) the sequencer walks the holding or input store one register at a time, each
// through an issue, a high byte and a low byte state, as the memory read port is registered, and
// sends station address, function, byte count, the words high byte first and the CRC low byte
// first. A valid write (function 16) is answered with its six header bytes and the CRC. No new
// item is taken while a reply is being sent, although the final reply byte may still wait in the
// output register. Both stores read as zero after reset; there is no clearing pass. The user
// must write the station address through the csr port only while the block is idle; the block
// does not enforce this. The station address resets to 1.
`default_nettype none
module modbus_rtu_register_slave_unit
   import mrs_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire req_item_type req_item,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output rsp_item_type      rsp_item,
   input  wire logic         csr_we,
   input  wire logic [7:0]   csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_HDR, ST_RD_ISSUE, ST_RD_HI, ST_RD_LO, ST_CRC_LO, ST_CRC_HI
   } state_type;

   state_type       state_ff, state_in;
   logic [7:0]      station_ff;
   logic [7:0]      pos_ff, pos_in;
   logic [47:0]     hdr_ff, hdr_in;
   logic [7:0]      wbc_ff, wbc_in;
   logic [7:0]      low_ff, low_in;
   logic            rej_ff, rej_in;
   logic [47:0]     rep_buf_ff, rep_buf_in;
   logic [2:0]      rep_cnt_ff, rep_cnt_in;
   logic            rep_write_ff, rep_write_in;
   logic            rep_input_ff, rep_input_in;
   logic [REG_ADDR_W-1:0] addr_ff, addr_in;
   logic [4:0]      words_ff, words_in;
   logic [15:0]     crc_ff, crc_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_item_type    rsp_item_ff, rsp_item_in;

   // Request fields as they stood before the current byte.
   logic [7:0]  func;
   logic [15:0] start, num;
   logic [16:0] span;
   logic        byte_acc, load_acc;
   logic [7:0]  b, d;
   logic        hold_we;
   logic [REG_ADDR_W-1:0] hold_waddr;
   logic [15:0] hold_wdata;
   logic        rd_ok, wr_ok;
   logic [8:0]  wr_need;

   // Emission of one reply byte into the output register.
   logic        slot_free, emit_go, emit_crc;
   logic [7:0]  emit_byte;
   logic        emit_last;
   logic        hold_re, input_re;
   logic [15:0] hold_rdata, input_rdata, rd_word;

   assign func  = hdr_ff[39:32];
   assign start = hdr_ff[31:16];
   assign num   = hdr_ff[15:0];
   assign span  = {1'b0, start} + {1'b0, num};
   assign b     = req_item.data_byte;
   assign d     = pos_ff - 8'd7;

   assign req_ready = (state_ff == ST_IDLE);
   assign byte_acc  = req_valid && req_ready && (req_item.operation == OP_FRAME_BYTE);
   assign load_acc  = req_valid && req_ready && (req_item.operation == OP_LOAD_INPUT);

   always_comb begin
      pos_in       = pos_ff;
      hdr_in       = hdr_ff;
      wbc_in       = wbc_ff;
      low_in       = low_ff;
      rej_in       = rej_ff;
      hold_we      = 1'b0;
      hold_waddr   = start[REG_ADDR_W-1:0] + REG_ADDR_W'(d[7:1]);
      hold_wdata   = {low_ff, b};
      rd_ok        = 1'b0;
      wr_ok        = 1'b0;
      wr_need      = 9'd0;
      if (!rej_ff) begin
         if (pos_ff < 8'd6) begin
            case (pos_ff[2:0])
               3'd0: hdr_in[47:40] = b;
               3'd1: hdr_in[39:32] = b;
               3'd2: hdr_in[31:24] = b;
               3'd3: hdr_in[23:16] = b;
               3'd4: hdr_in[15:8]  = b;
               default: hdr_in[7:0] = b;
            endcase
            if (pos_ff == 8'd0 && b != station_ff && b != BCAST_ADDR) begin
               rej_in = 1'b1;
            end
            if (pos_ff == 8'd1 && b != FN_READ_HOLD && b != FN_READ_INPUT
                && b != FN_WRITE_MULTI) begin
               rej_in = 1'b1;
            end
         end else if (func == FN_WRITE_MULTI) begin
            if (pos_ff == 8'd6) begin
               if (num < 16'd1 || num > 16'(MAX_WRITE_REGS) || {8'h00, b} != {num[14:0], 1'b0}
                   || span > 17'(REG_DEPTH)) begin
                  rej_in = 1'b1;
               end else begin
                  wbc_in = b;
               end
            end else if (pos_ff != 8'd255) begin
               if (d < wbc_ff) begin
                  if (!d[0]) begin
                     low_in = b;
                  end else begin
                     hold_we = byte_acc;
                  end
               end
            end
         end
      end
      wr_need = 9'd6 + {1'b0, wbc_in};
      if (!req_item.frame_last) begin
         if (pos_ff != 8'd255) begin
            pos_in = pos_ff + 8'd1;
         end
      end else begin
         if (!rej_in) begin
            rd_ok = (func == FN_READ_HOLD || func == FN_READ_INPUT) && pos_ff >= 8'd5
                    && num >= 16'd1 && num <= 16'(MAX_READ_REGS) && span <= 17'(REG_DEPTH);
            wr_ok = (func == FN_WRITE_MULTI) && pos_ff >= 8'd6 && {1'b0, pos_ff} >= wr_need;
         end
         pos_in = 8'd0;
         rej_in = 1'b0;
         hdr_in = '0;
      end
   end

   mrs_regfile #(.DEPTH(REG_DEPTH), .WIDTH(REG_WIDTH)) u_holding (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (hold_we),
      .wr_addr (hold_waddr),
      .wr_data (hold_wdata),
      .rd_en   (hold_re),
      .rd_addr (addr_ff),
      .rd_data (hold_rdata)
   );

   mrs_regfile #(.DEPTH(REG_DEPTH), .WIDTH(REG_WIDTH)) u_input (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (load_acc),
      .wr_addr (req_item.reg_index[REG_ADDR_W-1:0]),
      .wr_data (req_item.reg_value),
      .rd_en   (input_re),
      .rd_addr (addr_ff),
      .rd_data (input_rdata)
   );

   assign hold_re   = (state_ff == ST_RD_ISSUE) && !rep_input_ff;
   assign input_re  = (state_ff == ST_RD_ISSUE) && rep_input_ff;
   assign rd_word   = rep_input_ff ? input_rdata : hold_rdata;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      emit_byte = rep_buf_ff[47:40];
      emit_last = 1'b0;
      emit_crc  = 1'b1;
      case (state_ff)
         ST_HDR:    emit_byte = rep_buf_ff[47:40];
         ST_RD_HI:  emit_byte = rd_word[15:8];
         ST_RD_LO:  emit_byte = rd_word[7:0];
         ST_CRC_LO: begin
            emit_byte = crc_ff[7:0];
            emit_crc  = 1'b0;
         end
         ST_CRC_HI: begin
            emit_byte = crc_ff[15:8];
            emit_last = 1'b1;
            emit_crc  = 1'b0;
         end
         default:   emit_crc = 1'b0;
      endcase
      emit_go = slot_free && (state_ff == ST_HDR || state_ff == ST_RD_HI
                || state_ff == ST_RD_LO || state_ff == ST_CRC_LO || state_ff == ST_CRC_HI);
   end

   always_comb begin
      state_in     = state_ff;
      rep_buf_in   = rep_buf_ff;
      rep_cnt_in   = rep_cnt_ff;
      rep_write_in = rep_write_ff;
      rep_input_in = rep_input_ff;
      addr_in      = addr_ff;
      words_in     = words_ff;
      crc_in       = crc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_item_in  = rsp_item_ff;
      if (emit_go) begin
         rsp_valid_in        = 1'b1;
         rsp_item_in.tx_byte = emit_byte;
         rsp_item_in.tx_last = emit_last;
         if (emit_crc) begin
            crc_in = crc16_step(crc_ff, emit_byte);
         end
      end
      case (state_ff)
         ST_IDLE: begin
            // Loads the reply set-up at the end of an accepted frame.
            if (byte_acc && req_item.frame_last && (rd_ok || wr_ok)) begin
               crc_in   = CRC_INIT;
               state_in = ST_HDR;
               if (rd_ok) begin
                  rep_buf_in   = {station_ff, func, num[6:0], 1'b0, 24'h000000};
                  rep_cnt_in   = 3'd3;
                  rep_write_in = 1'b0;
                  rep_input_in = (func == FN_READ_INPUT);
                  addr_in      = start[REG_ADDR_W-1:0];
                  words_in     = num[4:0];
               end else begin
                  rep_buf_in   = hdr_ff;
                  rep_cnt_in   = 3'd6;
                  rep_write_in = 1'b1;
                  rep_input_in = 1'b0;
               end
            end
         end
         ST_HDR: begin
            if (emit_go) begin
               rep_buf_in = {rep_buf_ff[39:0], 8'h00};
               rep_cnt_in = rep_cnt_ff - 3'd1;
               if (rep_cnt_ff == 3'd1) begin
                  state_in = rep_write_ff ? ST_CRC_LO : ST_RD_ISSUE;
               end
            end
         end
         ST_RD_ISSUE: state_in = ST_RD_HI;
         ST_RD_HI: begin
            if (emit_go) begin
               state_in = ST_RD_LO;
            end
         end
         ST_RD_LO: begin
            if (emit_go) begin
               addr_in  = addr_ff + REG_ADDR_W'(1);
               words_in = words_ff - 5'd1;
               state_in = (words_ff == 5'd1) ? ST_CRC_LO : ST_RD_ISSUE;
            end
         end
         ST_CRC_LO: begin
            if (emit_go) begin
               state_in = ST_CRC_HI;
            end
         end
         ST_CRC_HI: begin
            if (emit_go) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         station_ff   <= STATION_RESET;
         pos_ff       <= '0;
         hdr_ff       <= '0;
         wbc_ff       <= '0;
         low_ff       <= '0;
         rej_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            station_ff <= csr_wdata;
         end
         if (byte_acc) begin
            pos_ff <= pos_in;
            hdr_ff <= hdr_in;
            wbc_ff <= wbc_in;
            low_ff <= low_in;
            rej_ff <= rej_in;
         end
      end
      rep_buf_ff   <= rep_buf_in;
      rep_cnt_ff   <= rep_cnt_in;
      rep_write_ff <= rep_write_in;
      rep_input_ff <= rep_input_in;
      addr_ff      <= addr_in;
      words_ff     <= words_in;
      crc_ff       <= crc_in;
      rsp_item_ff  <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule
`default_nettype wire

// ----- hdl/mrs_checker.sv -----
// Port-level checker for the Modbus RTU register slave, bound to the top level.
// Uses mrs_pkg for the item types.
`default_nettype none
module mrs_checker
   import mrs_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_valid,
   input wire logic         req_ready,
   input wire req_item_type req_item,
   input wire logic         rsp_valid,
   input wire logic         rsp_ready,
   input wire rsp_item_type rsp_item
);

   // A stalled reply item holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
      else $error("reply item changed while stalled");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("reply valid after reset");

   // An input load never starts a reply.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_item.operation == OP_LOAD_INPUT && !rsp_valid |=> !rsp_valid)
      else $error("reply after input load");

   // Only the marked byte of a frame can start a reply.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_item.operation == OP_FRAME_BYTE && !req_item.frame_last
      && !rsp_valid |=> !rsp_valid)
      else $error("reply before end of frame");

   // Nothing follows the last reply byte directly.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_item.tx_last |=> !rsp_valid)
      else $error("reply byte after last byte");

endmodule

bind modbus_rtu_register_slave_unit mrs_checker u_mrs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_item  (req_item),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_item  (rsp_item)
);
`default_nettype wire

// ----- tb/modbus_rtu_register_slave_unit_tb.sv -----
// Self-checking testbench for the Modbus RTU register slave top level.
// Depends on mrs_pkg and the block's RTL; it predicts reply bytes from its own model.
`timescale 1ns / 1ps
module modbus_rtu_register_slave_unit_tb;
   import mrs_pkg::*;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_item_type req_item;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_item_type rsp_item;
   logic         csr_we;
   logic [7:0]   csr_wdata;

   modbus_rtu_register_slave_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // Pending request items, and the reply bytes that the predictor expects in order.
   req_item_type pending_items[$];
   rsp_item_type expected_bytes[$];
   int           fail_count = 0;
   bit           stimulus_done = 0;
   // Set by the stimulus process to ask the reply side for one long hold-off.
   bit           hold_request = 0;

   // The predictor's own copy of the slave's state.
   logic [7:0]  my_station;
   logic [15:0] hold_store [REG_DEPTH];
   logic [15:0] input_store [REG_DEPTH];
   logic [7:0]  frame_pos;
   logic [7:0]  frame_hdr [6];
   logic [7:0]  wr_count;
   logic [7:0]  word_high;
   logic        frame_dropped;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int j = 0; j < 8; j++) begin
         c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
      end
      return c;
   endfunction

   task automatic push_byte(inout logic [15:0] crc, input logic [7:0] b);
      rsp_item_type r;
      r.tx_byte = b;
      r.tx_last = 1'b0;
      expected_bytes.push_back(r);
      crc = crc_byte(crc, b);
   endtask

   task automatic push_crc(input logic [15:0] crc);
      rsp_item_type r;
      r.tx_byte = crc[7:0];
      r.tx_last = 1'b0;
      expected_bytes.push_back(r);
      r.tx_byte = crc[15:8];
      r.tx_last = 1'b1;
      expected_bytes.push_back(r);
   endtask

   task automatic reset_model();
      my_station = STATION_RESET;
      for (int i = 0; i < REG_DEPTH; i++) begin
         hold_store[i]  = '0;
         input_store[i] = '0;
      end
      frame_pos = '0;
      for (int i = 0; i < 6; i++) frame_hdr[i] = '0;
      wr_count = '0;
      word_high = '0;
      frame_dropped = 1'b0;
   endtask

   // Works out the reply bytes of one accepted item and queues them.
   task automatic predict_reply(input req_item_type it);
      int          pos, start, count, received, d;
      logic [7:0]  fn, b;
      logic [15:0] crc, w;
      if (it.operation == OP_LOAD_INPUT) begin
         input_store[it.reg_index] = it.reg_value;
         return;
      end
      b = it.data_byte;
      pos = frame_pos;
      fn = frame_hdr[1];
      start = {frame_hdr[2], frame_hdr[3]};
      count = {frame_hdr[4], frame_hdr[5]};
      if (!frame_dropped) begin
         if (pos < 6) begin
            frame_hdr[pos] = b;
            if (pos == 0 && b != my_station && b != BCAST_ADDR) frame_dropped = 1'b1;
            if (pos == 1 && b != FN_READ_HOLD && b != FN_READ_INPUT && b != FN_WRITE_MULTI)
               frame_dropped = 1'b1;
         end else if (fn == FN_WRITE_MULTI) begin
            if (pos == 6) begin
               if (count < 1 || count > MAX_WRITE_REGS || b != ((2 * count) & 8'hFF) ||
                   start + count > REG_DEPTH)
                  frame_dropped = 1'b1;
               else
                  wr_count = b;
            end else if (pos < 255) begin
               d = pos - 7;
               if (d < wr_count) begin
                  if (d % 2 == 0) word_high = b;
                  else hold_store[(start + d / 2) % REG_DEPTH] = {word_high, b};
               end
            end
         end
      end
      if (!it.frame_last) begin
         if (pos < 255) frame_pos = pos + 1;
         return;
      end
      if (!frame_dropped) begin
         received = pos + 1;
         crc = CRC_INIT;
         if ((fn == FN_READ_HOLD || fn == FN_READ_INPUT) && received >= 6 && count >= 1 &&
             count <= MAX_READ_REGS && start + count <= REG_DEPTH) begin
            push_byte(crc, my_station);
            push_byte(crc, fn);
            push_byte(crc, 8'(2 * count));
            for (int i = 0; i < count; i++) begin
               w = (fn == FN_READ_HOLD) ? hold_store[(start + i) % REG_DEPTH]
                                        : input_store[(start + i) % REG_DEPTH];
               push_byte(crc, w[15:8]);
               push_byte(crc, w[7:0]);
            end
            push_crc(crc);
         end else if (fn == FN_WRITE_MULTI && received >= 7 && received >= 7 + wr_count) begin
            for (int i = 0; i < 6; i++) push_byte(crc, frame_hdr[i]);
            push_crc(crc);
         end
      end
      frame_pos = '0;
      frame_dropped = 1'b0;
      for (int i = 0; i < 6; i++) frame_hdr[i] = '0;
   endtask

   // Queues one request byte; the last byte of a frame carries the end mark.
   task automatic add_byte(input logic [7:0] b, input logic last);
      req_item_type it;
      it.operation  = OP_FRAME_BYTE;
      it.data_byte  = b;
      it.frame_last = last;
      it.reg_index  = 6'($urandom);
      it.reg_value  = 16'($urandom);
      pending_items.push_back(it);
   endtask

   task automatic add_load(input logic [5:0] idx, input logic [15:0] val);
      req_item_type it;
      it.operation  = OP_LOAD_INPUT;
      it.data_byte  = 8'($urandom);
      it.frame_last = 1'($urandom);
      it.reg_index  = idx;
      it.reg_value  = val;
      pending_items.push_back(it);
   endtask

   // A read or short/odd header frame of n bytes (n <= 8); the two trailing bytes act as CRC.
   task automatic add_read(input logic [7:0] addr, input logic [7:0] fn, input int start,
                           input int count, input int n);
      logic [7:0] bytes [8];
      bytes = '{addr, fn, 8'(start >> 8), 8'(start), 8'(count >> 8), 8'(count),
                8'($urandom), 8'($urandom)};
      for (int i = 0; i < n; i++) add_byte(bytes[i], i == n - 1);
   endtask

   // A multiple write; data_len bytes of data are sent (short when less than 2*count).
   task automatic add_write(input logic [7:0] addr, input int start, input int count,
                            input logic [7:0] bc, input int data_len, input int tail);
      add_byte(addr, 0);
      add_byte(FN_WRITE_MULTI, 0);
      add_byte(8'(start >> 8), 0);
      add_byte(8'(start), 0);
      add_byte(8'(count >> 8), 0);
      add_byte(8'(count), 0);
      add_byte(bc, data_len + tail == 0);
      for (int i = 0; i < data_len + tail; i++) begin
         add_byte(8'($urandom), i == data_len + tail - 1);
      end
   endtask

   task automatic wait_drained();
      while (pending_items.size() != 0 || req_valid || expected_bytes.size() != 0)
         @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic write_station(input logic [7:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      my_station = value;
   endtask

   // Random traffic: mostly well-formed frames with random content, some noise.
   task automatic add_random(input int items);
      int goal, cnt, st;
      logic [7:0] addr;
      goal = pending_items.size() + items;
      while (pending_items.size() < goal) begin
         addr = ($urandom_range(0, 3) == 0) ? BCAST_ADDR :
                ($urandom_range(0, 5) == 0) ? 8'($urandom) : my_station;
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 29) : $urandom_range(1, 4);
               st = $urandom_range(0, REG_DEPTH - cnt);
               if ($urandom_range(0, 7) == 0) cnt = $urandom_range(0, 40);
               add_read(addr, $urandom_range(0, 1) ? FN_READ_HOLD : FN_READ_INPUT, st, cnt,
                        $urandom_range(0, 7) == 0 ? $urandom_range(1, 8) : 8);
            end
            3, 4, 5: begin
               cnt = $urandom_range(1, 4);
               st = $urandom_range(0, REG_DEPTH - cnt);
               if ($urandom_range(0, 7) == 0)
                  add_write(addr, st, cnt, 8'(2 * cnt), $urandom_range(0, 2 * cnt - 1), 0);
               else
                  add_write(addr, st, cnt, 8'(2 * cnt), 2 * cnt, 2);
            end
            6, 7: add_load(6'($urandom), 16'($urandom));
            8: add_read(addr, 8'($urandom), $urandom_range(0, 63), $urandom_range(1, 4), 8);
            default: add_byte(8'($urandom), 1'($urandom));
         endcase
      end
   endtask

   // Sender: one item offered after a random gap, held until it is taken.
   int send_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_item  <= '0;
         send_gap  <= 0;
      end else if (req_valid && !req_ready) begin
         // Item still on offer: nothing changes.
      end else begin
         if (req_valid) begin
            predict_reply(req_item);
         end
         if (send_gap != 0) begin
            send_gap  <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_items.size() != 0) begin
            req_item  <= pending_items.pop_front();
            req_valid <= 1'b1;
            send_gap  <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off on request.
   int recv_gap = 0;
   int hold_cycles = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready   <= 1'b0;
         recv_gap    <= 0;
         hold_cycles <= 0;
      end else if (hold_request && hold_cycles == 0) begin
         hold_cycles <= 400;
         rsp_ready   <= 1'b0;
      end else if (hold_cycles > 1) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ready   <= 1'b0;
      end else if (recv_gap != 0) begin
         recv_gap  <= recv_gap - 1;
         rsp_ready <= 1'b0;
         hold_cycles <= 0;
      end else begin
         rsp_ready <= 1'b1;
         hold_cycles <= 0;
         if (rsp_valid && rsp_ready)
            recv_gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13);
      end
   end

   // Monitor: compares each accepted reply byte with the oldest expectation.
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_bytes.size() == 0) begin
            $display("%t: unexpected reply byte %h last %b", $realtime,
                     rsp_item.tx_byte, rsp_item.tx_last);
            fail_count++;
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_item.tx_byte !== want.tx_byte) begin
               $display("%t: tx_byte expected %h actual %h", $realtime,
                        want.tx_byte, rsp_item.tx_byte);
               fail_count++;
            end
            if (rsp_item.tx_last !== want.tx_last) begin
               $display("%t: tx_last expected %b actual %b", $realtime,
                        want.tx_last, rsp_item.tx_last);
               fail_count++;
            end
         end
      end
   end

   initial begin
      reset     = 1'b1;
      csr_we    = 1'b0;
      csr_wdata = '0;
      reset_model();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part with the reset station address: loads at both index extremes, a full
      // write, both reads, broadcast, mismatched address, unknown function and short frames.
      add_load(6'd0, 16'hFFFF);
      add_load(6'd63, 16'h8001);
      add_read(STATION_RESET, FN_READ_INPUT, 62, 2, 8);
      add_write(BCAST_ADDR, 0, 2, 8'd4, 4, 2);
      add_read(BCAST_ADDR, FN_READ_HOLD, 0, 29, 8);
      add_read(8'd7, FN_READ_HOLD, 0, 1, 8);
      add_read(STATION_RESET, 8'd5, 0, 1, 8);
      add_read(STATION_RESET, FN_READ_HOLD, 0, 1, 5);
      add_read(STATION_RESET, FN_READ_HOLD, 60, 5, 8);
      add_write(STATION_RESET, 62, 2, 8'd3, 4, 0);
      add_write(STATION_RESET, 10, 2, 8'd4, 3, 0);
      add_read(STATION_RESET, FN_READ_HOLD, 10, 2, 6);
      wait_drained();

      // A read frame with many trailing bytes, then a normal read.
      write_station(8'd247);
      add_byte(8'd247, 0);
      add_byte(FN_READ_HOLD, 0);
      for (int i = 0; i < 20; i++) add_byte(8'($urandom), i == 19);
      add_read(8'd247, FN_READ_HOLD, 0, 3, 8);
      wait_drained();

      // Receiver holds off while the sender keeps offering long reads.
      hold_request = 1'b1;
      for (int i = 0; i < 4; i++) add_read(8'd247, FN_READ_INPUT, 0, 29, 8);
      repeat (20) @(posedge clock);
      hold_request = 1'b0;
      wait_drained();

      write_station(8'd1);
      add_random(20);
      wait_drained();
      write_station(8'($urandom_range(2, 246)));
      add_random(20);
      wait_drained();
      write_station(8'd247);
      add_random(20);
      wait_drained();
      stimulus_done = 1'b1;
   end

   initial begin
      wait (stimulus_done);
      if (fail_count == 0 && expected_bytes.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #20ms;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/mrs_pkg.sv
hdl/mrs_regfile.sv
hdl/modbus_rtu_register_slave_unit.sv
hdl/mrs_checker.sv
tb/modbus_rtu_register_slave_unit_tb.sv
